[src/afsw_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// afsw_pkg
// shared constants and codes for the affine texture span walker
// ----------------------------------------------------------------------------
package afsw_pkg;

   localparam int DEF_SCREEN_WIDTH  = 320;
   localparam int DEF_SCREEN_HEIGHT = 200;

   localparam int ROW_W   = 8;
   localparam int X_W     = 16;
   localparam int COORD_W = 32;
   localparam int ADDR_W  = 16;
   localparam int CSR_IDX_W = 8;

   typedef enum logic {
      CMD_START = 1'b0,
      CMD_TICK  = 1'b1
   } command_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_U_STEP = 8'd0,
      CSR_V_STEP = 8'd1
   } csr_index_type;

endpackage : afsw_pkg
`default_nettype wire

[src/afsw_csr.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// afsw_csr
// per-pixel u and v step registers, written through the csr channel
// ----------------------------------------------------------------------------
module afsw_csr (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          csr_valid,
   input  wire logic [afsw_pkg::CSR_IDX_W-1:0] csr_index,
   input  wire logic [afsw_pkg::COORD_W-1:0]  csr_wdata,
   output logic                               csr_ready,
   output logic [afsw_pkg::COORD_W-1:0]       u_step,
   output logic [afsw_pkg::COORD_W-1:0]       v_step
);
   import afsw_pkg::*;

   logic [COORD_W-1:0] u_step_ff;
   logic [COORD_W-1:0] u_step_in;
   logic [COORD_W-1:0] v_step_ff;
   logic [COORD_W-1:0] v_step_in;

   assign csr_ready = 1'b1;

   always_comb begin
      u_step_in = u_step_ff;
      v_step_in = v_step_ff;
      if (csr_valid) begin
         unique case (csr_index)
            CSR_U_STEP: u_step_in = csr_wdata;
            CSR_V_STEP: v_step_in = csr_wdata;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         u_step_ff <= '0;
         v_step_ff <= '0;
      end else begin
         u_step_ff <= u_step_in;
         v_step_ff <= v_step_in;
      end
   end

   assign u_step = u_step_ff;
   assign v_step = v_step_ff;

endmodule : afsw_csr
`default_nettype wire

[src/afsw_setup.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// afsw_setup
// clips a start item to the screen and computes the first pixel's state
// ----------------------------------------------------------------------------
module afsw_setup #(
   parameter int SCREEN_WIDTH  = afsw_pkg::DEF_SCREEN_WIDTH,
   parameter int SCREEN_HEIGHT = afsw_pkg::DEF_SCREEN_HEIGHT,
   localparam int COL_W = $clog2(SCREEN_WIDTH)
) (
   input  wire logic [afsw_pkg::ROW_W-1:0]          row,
   input  wire logic signed [afsw_pkg::X_W-1:0]     left_x,
   input  wire logic signed [afsw_pkg::X_W-1:0]     right_x,
   input  wire logic [afsw_pkg::COORD_W-1:0]        u_start,
   input  wire logic [afsw_pkg::COORD_W-1:0]        v_start,
   input  wire logic [afsw_pkg::COORD_W-1:0]        u_step,
   input  wire logic [afsw_pkg::COORD_W-1:0]        v_step,
   output logic                                     span_ok,
   output logic [afsw_pkg::ADDR_W-1:0]              pixel_start,
   output logic [COL_W-1:0]                         pixel_count,
   output logic [afsw_pkg::COORD_W-1:0]             u_first,
   output logic [afsw_pkg::COORD_W-1:0]             v_first
);
   import afsw_pkg::*;

   localparam logic signed [X_W-1:0] X_MAX     = X_W'(SCREEN_WIDTH - 1);
   localparam logic [ADDR_W-1:0]     ROW_PITCH = ADDR_W'(SCREEN_WIDTH);
   localparam logic [X_W-1:0]        ROW_LIMIT = X_W'(SCREEN_HEIGHT);

   logic                         row_ok;
   logic                         x_ok;
   logic [COL_W-1:0]             x1_clip;
   logic [COL_W-1:0]             x2_clip;
   logic [X_W-1:0]               skip;
   logic [COORD_W-1:0]           u_skip;
   logic [COORD_W-1:0]           v_skip;
   logic [ADDR_W-1:0]            row_base;

   assign row_ok = X_W'(row) < ROW_LIMIT;
   assign x_ok   = !(left_x > X_MAX) && !right_x[X_W-1];

   assign x2_clip = (right_x > X_MAX) ? X_MAX[COL_W-1:0] : right_x[COL_W-1:0];
   assign x1_clip = left_x[X_W-1] ? '0 : left_x[COL_W-1:0];

   // pixels skipped left of column 0
   assign skip   = X_W'(-left_x);
   assign u_skip = u_step * COORD_W'(skip);
   assign v_skip = v_step * COORD_W'(skip);

   assign u_first = left_x[X_W-1] ? u_start + u_skip : u_start;
   assign v_first = left_x[X_W-1] ? v_start + v_skip : v_start;

   assign span_ok     = row_ok && x_ok && (x2_clip > x1_clip);
   assign pixel_count = x2_clip - x1_clip;

   assign row_base    = ADDR_W'(row) * ROW_PITCH;
   assign pixel_start = row_base + ADDR_W'(x1_clip);

endmodule : afsw_setup
`default_nettype wire

[src/afsw_walker.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// afsw_walker
// span state registers, per-pixel stepping and the result register
// ----------------------------------------------------------------------------
module afsw_walker #(
   parameter int SCREEN_WIDTH = afsw_pkg::DEF_SCREEN_WIDTH,
   localparam int COL_W = $clog2(SCREEN_WIDTH)
) (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            item_valid,
   input  wire afsw_pkg::command_type           item_command,
   output logic                                 item_ready,
   input  wire logic                            span_ok,
   input  wire logic [afsw_pkg::ADDR_W-1:0]     pixel_start,
   input  wire logic [COL_W-1:0]                pixel_count,
   input  wire logic [afsw_pkg::COORD_W-1:0]    u_first,
   input  wire logic [afsw_pkg::COORD_W-1:0]    v_first,
   input  wire logic [afsw_pkg::COORD_W-1:0]    u_step,
   input  wire logic [afsw_pkg::COORD_W-1:0]    v_step,
   output logic                                 span_active,
   output logic                                 rsp_valid,
   input  wire logic                            rsp_stall,
   output logic [afsw_pkg::ADDR_W-1:0]          rsp_pixel_address,
   output logic [afsw_pkg::ADDR_W-1:0]          rsp_texel_address,
   output logic                                 rsp_span_end
);
   import afsw_pkg::*;

   logic                 active_ff;
   logic                 active_in;
   logic [ADDR_W-1:0]    pixel_ff;
   logic [ADDR_W-1:0]    pixel_in;
   logic [COL_W-1:0]     left_ff;
   logic [COL_W-1:0]     left_in;
   logic [COORD_W-1:0]   u_ff;
   logic [COORD_W-1:0]   u_in;
   logic [COORD_W-1:0]   v_ff;
   logic [COORD_W-1:0]   v_in;
   logic                 rsp_valid_ff;
   logic                 rsp_valid_in;
   logic [ADDR_W-1:0]    pixel_addr_ff;
   logic [ADDR_W-1:0]    pixel_addr_in;
   logic [ADDR_W-1:0]    texel_addr_ff;
   logic [ADDR_W-1:0]    texel_addr_in;
   logic                 span_end_ff;
   logic                 span_end_in;
   logic                 take;
   logic                 last;

   assign item_ready = !rsp_valid_ff || !rsp_stall;
   assign take       = item_valid && item_ready;
   assign last       = left_ff == COL_W'(1);

   always_comb begin
      active_in     = active_ff;
      pixel_in      = pixel_ff;
      left_in       = left_ff;
      u_in          = u_ff;
      v_in          = v_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      pixel_addr_in = pixel_addr_ff;
      texel_addr_in = texel_addr_ff;
      span_end_in   = span_end_ff;
      if (take) begin
         case (item_command)
            CMD_START: begin
               active_in = span_ok;
               pixel_in  = pixel_start;
               left_in   = pixel_count;
               u_in      = u_first;
               v_in      = v_first;
            end
            CMD_TICK: begin
               if (active_ff) begin
                  rsp_valid_in  = 1'b1;
                  pixel_addr_in = pixel_ff;
                  texel_addr_in = {v_ff[23:16], u_ff[23:16]};
                  span_end_in   = last;
                  active_in     = !last;
                  pixel_in      = pixel_ff + ADDR_W'(1);
                  left_in       = left_ff - COL_W'(1);
                  u_in          = u_ff + u_step;
                  v_in          = v_ff + v_step;
               end
            end
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         active_ff    <= active_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      pixel_ff      <= pixel_in;
      left_ff       <= left_in;
      u_ff          <= u_in;
      v_ff          <= v_in;
      pixel_addr_ff <= pixel_addr_in;
      texel_addr_ff <= texel_addr_in;
      span_end_ff   <= span_end_in;
   end

   assign span_active       = active_ff;
   assign rsp_valid         = rsp_valid_ff;
   assign rsp_pixel_address = pixel_addr_ff;
   assign rsp_texel_address = texel_addr_ff;
   assign rsp_span_end      = span_end_ff;

endmodule : afsw_walker
`default_nettype wire

[src/affine_texture_span_walker.sv]
`timescale 1ns / 1ps
`default_nettype none
// an accepted item passes through the input register, then the result register
// throughput: one item per cycle while the result side does not stall, start and tick
//    items alike, set by the span state update in the walker
// a start item gives no result, a tick gives one pixel while a span is active
// reset: span cleared, input and result registers empty, u and v steps zero
// ----------------------------------------------------------------------------
// affine_texture_span_walker
// walks one clipped horizontal span, one framebuffer and texel address per tick
// ----------------------------------------------------------------------------
module affine_texture_span_walker #(
   parameter int SCREEN_WIDTH  = afsw_pkg::DEF_SCREEN_WIDTH,
   parameter int SCREEN_HEIGHT = afsw_pkg::DEF_SCREEN_HEIGHT
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              req_valid,
   output logic                                   req_stall,
   input  wire logic                              req_command,
   input  wire logic [afsw_pkg::ROW_W-1:0]        req_row,
   input  wire logic signed [afsw_pkg::X_W-1:0]   req_left_x,
   input  wire logic signed [afsw_pkg::X_W-1:0]   req_right_x,
   input  wire logic signed [afsw_pkg::COORD_W-1:0] req_u_start,
   input  wire logic signed [afsw_pkg::COORD_W-1:0] req_v_start,
   output logic                                   rsp_valid,
   input  wire logic                              rsp_stall,
   output logic [afsw_pkg::ADDR_W-1:0]            rsp_pixel_address,
   output logic [afsw_pkg::ADDR_W-1:0]            rsp_texel_address,
   output logic                                   rsp_span_end,
   input  wire logic                              csr_valid,
   output logic                                   csr_ready,
   input  wire logic [afsw_pkg::CSR_IDX_W-1:0]    csr_index,
   input  wire logic [afsw_pkg::COORD_W-1:0]      csr_wdata
);
   import afsw_pkg::*;

   localparam int COL_W = $clog2(SCREEN_WIDTH);

   logic                      in_valid_ff;
   logic                      in_valid_in;
   command_type               cmd_ff;
   logic [ROW_W-1:0]          row_ff;
   logic signed [X_W-1:0]     left_x_ff;
   logic signed [X_W-1:0]     right_x_ff;
   logic [COORD_W-1:0]        u_start_ff;
   logic [COORD_W-1:0]        v_start_ff;
   logic                      item_ready;
   logic                      load;
   logic [COORD_W-1:0]        u_step;
   logic [COORD_W-1:0]        v_step;
   logic                      span_ok;
   logic [ADDR_W-1:0]         pixel_start;
   logic [COL_W-1:0]          pixel_count;
   logic [COORD_W-1:0]        u_first;
   logic [COORD_W-1:0]        v_first;
   logic                      span_active;

   assign req_stall   = in_valid_ff && !item_ready;
   assign load        = req_valid && !req_stall;
   assign in_valid_in = req_stall ? in_valid_ff : req_valid;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         cmd_ff     <= command_type'(req_command);
         row_ff     <= req_row;
         left_x_ff  <= req_left_x;
         right_x_ff <= req_right_x;
         u_start_ff <= req_u_start;
         v_start_ff <= req_v_start;
      end
   end

   afsw_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .csr_ready (csr_ready),
      .u_step    (u_step),
      .v_step    (v_step)
   );

   afsw_setup #(
      .SCREEN_WIDTH  (SCREEN_WIDTH),
      .SCREEN_HEIGHT (SCREEN_HEIGHT)
   ) u_setup (
      .row         (row_ff),
      .left_x      (left_x_ff),
      .right_x     (right_x_ff),
      .u_start     (u_start_ff),
      .v_start     (v_start_ff),
      .u_step      (u_step),
      .v_step      (v_step),
      .span_ok     (span_ok),
      .pixel_start (pixel_start),
      .pixel_count (pixel_count),
      .u_first     (u_first),
      .v_first     (v_first)
   );

   afsw_walker #(
      .SCREEN_WIDTH (SCREEN_WIDTH)
   ) u_walker (
      .clock             (clock),
      .reset             (reset),
      .item_valid        (in_valid_ff),
      .item_command      (cmd_ff),
      .item_ready        (item_ready),
      .span_ok           (span_ok),
      .pixel_start       (pixel_start),
      .pixel_count       (pixel_count),
      .u_first           (u_first),
      .v_first           (v_first),
      .u_step            (u_step),
      .v_step            (v_step),
      .span_active       (span_active),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_pixel_address (rsp_pixel_address),
      .rsp_texel_address (rsp_texel_address),
      .rsp_span_end      (rsp_span_end)
   );

   // a start item never produces a result
   a_start_no_result: assert property (@(posedge clock) disable iff (reset)
      in_valid_ff && item_ready && (cmd_ff == CMD_START) |=> !rsp_valid)
      else $error("result after start item");

   // the last pixel of a span leaves no span active
   a_end_clears_span: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_span_end |-> !span_active)
      else $error("span still active after its last pixel");

   // a held result blocks a waiting item
   a_stall_backpressure: assert property (@(posedge clock) disable iff (reset)
      in_valid_ff && rsp_valid && rsp_stall |-> req_stall)
      else $error("input not stalled behind held result");

   // a tick outside a span changes nothing visible
   a_idle_tick_quiet: assert property (@(posedge clock) disable iff (reset)
      in_valid_ff && item_ready && (cmd_ff == CMD_TICK) && !span_active |=> !rsp_valid)
      else $error("result from tick without span");

endmodule : affine_texture_span_walker
`default_nettype wire

[bench/tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// self-checking bench for the affine texture span walker: directed idle ticks, clipping,
// restart and wraparound spans, a long result hold-off, then random spans
// under several step settings, each pixel checked against an in-bench walker
// ----------------------------------------------------------------------------
module tb;
   import afsw_pkg::*;

   localparam int SCREEN_W = DEF_SCREEN_WIDTH;
   localparam int SCREEN_H = DEF_SCREEN_HEIGHT;
   localparam int DRAIN_CYCLES = 8;
   localparam int LONG_HOLD = 200;
   localparam int CYCLE_LIMIT = 400000;
   localparam logic [CSR_IDX_W-1:0] CSR_SPARE = 8'hA5;

   typedef struct packed {
      logic [ADDR_W-1:0] pixel;
      logic [ADDR_W-1:0] texel;
      logic              last;
   } span_pixel_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                      req_valid = 1'b0;
   logic                      req_stall;
   command_type               req_command = CMD_START;
   logic [ROW_W-1:0]          req_row = '0;
   logic signed [X_W-1:0]     req_left_x = '0;
   logic signed [X_W-1:0]     req_right_x = '0;
   logic signed [COORD_W-1:0] req_u_start = '0;
   logic signed [COORD_W-1:0] req_v_start = '0;
   logic                      rsp_valid;
   logic                      rsp_stall = 1'b0;
   logic [ADDR_W-1:0]         rsp_pixel_address;
   logic [ADDR_W-1:0]         rsp_texel_address;
   logic                      rsp_span_end;
   logic                      csr_valid = 1'b0;
   logic                      csr_ready;
   logic [CSR_IDX_W-1:0]      csr_index = '0;
   logic [COORD_W-1:0]        csr_wdata = '0;

   // walker state mirrored in the bench
   bit          span_on = 1'b0;
   logic [31:0] next_addr = '0;
   int unsigned pixels_remaining = 0;
   logic [31:0] u_acc = '0;
   logic [31:0] v_acc = '0;
   logic [31:0] u_step_cur = '0;
   logic [31:0] v_step_cur = '0;

   span_pixel_type pending_pixels[$];
   int          errors = 0;
   int          work_count = 0;
   int          cycle_count = 0;
   bit          sender_idling = 1'b1;
   bit          receiver_idling = 1'b1;
   bit          hold_request = 1'b0;

   affine_texture_span_walker dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_command       (req_command),
      .req_row           (req_row),
      .req_left_x        (req_left_x),
      .req_right_x       (req_right_x),
      .req_u_start       (req_u_start),
      .req_v_start       (req_v_start),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_pixel_address (rsp_pixel_address),
      .rsp_texel_address (rsp_texel_address),
      .rsp_span_end      (rsp_span_end),
      .csr_valid         (csr_valid),
      .csr_ready         (csr_ready),
      .csr_index         (csr_index),
      .csr_wdata         (csr_wdata)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles", cycle_count);
         $display("tb failed");
         $finish;
      end
   end

   task automatic report_mismatch(input string msg);
      $display("mismatch at cycle %0d: %s", cycle_count, msg);
      errors++;
   endtask

   function automatic void walk_span(input command_type cmd, input logic [ROW_W-1:0] row,
                                     input logic signed [X_W-1:0] lx,
                                     input logic signed [X_W-1:0] rx,
                                     input logic [31:0] u, input logic [31:0] v);
      int          x1;
      int          x2;
      int          len;
      logic [31:0] skip;
      logic [31:0] uu;
      logic [31:0] vv;
      span_pixel_type px;
      if (cmd == CMD_START) begin
         work_count++;
         span_on = 1'b0;
         x1 = lx;
         x2 = rx;
         uu = u;
         vv = v;
         if (row >= SCREEN_H) return;
         if (x1 > SCREEN_W - 1 || x2 < 0) return;
         if (x2 > SCREEN_W - 1) x2 = SCREEN_W - 1;
         if (x1 < 0) begin
            skip = 32'(-x1);
            uu = uu + u_step_cur * skip;
            vv = vv + v_step_cur * skip;
            x1 = 0;
         end
         len = x2 - x1;
         if (len <= 0) return;
         span_on = 1'b1;
         next_addr = 32'(row) * SCREEN_W + 32'(x1);
         pixels_remaining = len;
         u_acc = uu;
         v_acc = vv;
      end else if (span_on) begin
         work_count++;
         px.pixel = next_addr[15:0];
         px.texel = {v_acc[23:16], u_acc[23:16]};
         px.last = (pixels_remaining == 1);
         pending_pixels.push_back(px);
         u_acc = u_acc + u_step_cur;
         v_acc = v_acc + v_step_cur;
         next_addr = next_addr + 1;
         pixels_remaining--;
         if (pixels_remaining == 0) span_on = 1'b0;
      end
   endfunction

   task automatic send_item(input command_type cmd, input logic [ROW_W-1:0] row,
                            input logic signed [X_W-1:0] lx, input logic signed [X_W-1:0] rx,
                            input logic [31:0] u, input logic [31:0] v);
      req_valid <= 1'b1;
      req_command <= cmd;
      req_row <= row;
      req_left_x <= lx;
      req_right_x <= rx;
      req_u_start <= u;
      req_v_start <= v;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      walk_span(cmd, row, lx, rx, u, v);
      if (sender_idling && $urandom_range(0, 5) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 16)) @(posedge clock);
      end
   endtask

   task automatic send_start(input logic [ROW_W-1:0] row, input int lx, input int rx,
                             input logic [31:0] u, input logic [31:0] v);
      send_item(CMD_START, row, X_W'(lx), X_W'(rx), u, v);
   endtask

   task automatic send_tick();
      send_item(CMD_TICK, ROW_W'($urandom), X_W'($urandom), X_W'($urandom), $urandom,
                $urandom);
   endtask

   task automatic wait_idle();
      req_valid <= 1'b0;
      while (pending_pixels.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_step(input logic [CSR_IDX_W-1:0] idx, input logic [31:0] value);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
      if (idx == CSR_U_STEP) u_step_cur = value;
      else if (idx == CSR_V_STEP) v_step_cur = value;
   endtask

   function automatic logic [31:0] pick_step();
      if ($urandom_range(0, 4) == 0) return $urandom;
      return 32'($urandom_range(0, 32'h60000)) - 32'h30000;
   endfunction

   task automatic random_span();
      logic [ROW_W-1:0]      row;
      logic signed [X_W-1:0] lx;
      logic signed [X_W-1:0] rx;
      int                    len;
      int                    ticks;
      if ($urandom_range(0, 11) == 0) send_tick();
      if ($urandom_range(0, 15) == 0) row = ROW_W'($urandom_range(SCREEN_H, 255));
      else row = ROW_W'($urandom_range(0, SCREEN_H - 1));
      case ($urandom_range(0, 9))
         0: lx = X_W'($urandom);
         1, 2: lx = X_W'(0 - int'($urandom_range(1, 40)));
         default: lx = X_W'($urandom_range(0, SCREEN_W + 5));
      endcase
      if ($urandom_range(0, 59) == 0) len = $urandom_range(100, 330);
      else len = $urandom_range(0, 12);
      if ($urandom_range(0, 19) == 0) rx = X_W'($urandom);
      else rx = X_W'(int'(lx) + len);
      send_item(CMD_START, row, lx, rx, $urandom, $urandom);
      ticks = span_on ? int'(pixels_remaining) : 0;
      case ($urandom_range(0, 7))
         0: ticks = $urandom_range(0, ticks);
         1: ticks = ticks + $urandom_range(1, 3);
         default: ;
      endcase
      repeat (ticks) send_tick();
   endtask

   task automatic test_idle_ticks();
      send_tick();
      send_tick();
      send_start(0, 0, 2, 32'h8000_0000, 32'h7fff_ffff);
      repeat (3) send_tick();
      wait_idle();
   endtask

   task automatic test_clipping();
      write_step(CSR_U_STEP, 32'h7fff_ffff);
      write_step(CSR_V_STEP, 32'h8000_0000);
      send_start(SCREEN_H - 1, -32768, 1, 32'h0, 32'h0);
      repeat (2) send_tick();
      send_start(SCREEN_H, 0, 10, $urandom, $urandom);
      send_tick();
      send_start(255, 0, 10, $urandom, $urandom);
      send_tick();
      send_start(17, SCREEN_W, SCREEN_W + 10, $urandom, $urandom);
      send_tick();
      send_start(17, 0, -1, $urandom, $urandom);
      send_tick();
      send_start(128, SCREEN_W - 3, 32767, 32'h0012_3456, 32'hffed_cba9);
      repeat (3) send_tick();
      send_start(64, 7, 7, $urandom, $urandom);
      send_tick();
      wait_idle();
   endtask

   task automatic test_restart_and_wrap();
      write_step(CSR_U_STEP, 32'h0001_0000);
      write_step(CSR_V_STEP, 32'hffff_0000);
      write_step(CSR_SPARE, 32'hdead_beef);
      send_start(3, 10, 20, 32'h7fff_0000, 32'h8000_0000);
      repeat (2) send_tick();
      send_start(100, -3, 2, 32'h7fff_8000, 32'h8000_8000);
      repeat (3) send_tick();
      wait_idle();
   endtask

   task automatic test_backpressure();
      write_step(CSR_U_STEP, pick_step());
      write_step(CSR_V_STEP, pick_step());
      sender_idling = 1'b0;
      hold_request = 1'b1;
      send_start(150, 0, 48, $urandom, $urandom);
      repeat (48) send_tick();
      wait_idle();
      sender_idling = 1'b1;
   endtask

   task automatic test_random_spans();
      int target;
      for (int phase = 0; phase < 5; phase++) begin
         wait_idle();
         case (phase)
            0: begin
               write_step(CSR_U_STEP, 32'h0000_0001);
               write_step(CSR_V_STEP, 32'hffff_ffff);
            end
            1: begin
               write_step(CSR_U_STEP, 32'h8000_0000);
               write_step(CSR_V_STEP, 32'h7fff_ffff);
            end
            default: begin
               write_step(CSR_U_STEP, pick_step());
               write_step(CSR_V_STEP, pick_step());
            end
         endcase
         target = work_count + 100;
         while (work_count < target) random_span();
      end
      wait_idle();
   endtask

   task automatic test_steady_stream();
      int target;
      sender_idling = 1'b0;
      receiver_idling = 1'b0;
      write_step(CSR_U_STEP, pick_step());
      write_step(CSR_V_STEP, pick_step());
      target = work_count + 100;
      while (work_count < target) random_span();
      wait_idle();
   endtask

   // result side hold-off, random bursts or one long stretch on request
   initial begin
      forever begin
         @(posedge clock);
         if (hold_request) begin
            rsp_stall <= 1'b1;
            repeat (LONG_HOLD) @(posedge clock);
            hold_request = 1'b0;
            rsp_stall <= 1'b0;
         end else if (receiver_idling && $urandom_range(0, 5) == 0) begin
            rsp_stall <= 1'b1;
            repeat ($urandom_range(1, 16)) @(posedge clock);
            rsp_stall <= 1'b0;
         end
      end
   end

   always @(posedge clock) begin : check_pixels
      span_pixel_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_pixels.size() == 0) begin
            report_mismatch($sformatf("item with nothing pending, pixel %0d",
                                      rsp_pixel_address));
         end else begin
            want = pending_pixels.pop_front();
            if (rsp_pixel_address !== want.pixel)
               report_mismatch($sformatf("pixel_address %0d, want %0d",
                                         rsp_pixel_address, want.pixel));
            if (rsp_texel_address !== want.texel)
               report_mismatch($sformatf("texel_address %h, want %h",
                                         rsp_texel_address, want.texel));
            if (rsp_span_end !== want.last)
               report_mismatch($sformatf("span_end %b, want %b", rsp_span_end, want.last));
         end
      end
   end

   initial begin
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_idle_ticks();
      test_clipping();
      test_restart_and_wrap();
      test_backpressure();
      test_random_spans();
      test_steady_stream();
      if (errors == 0) begin
         $display("tb passed");
      end else begin
         $display("tb failed");
      end
      $finish;
   end

endmodule
